// ===== hdl/rddh_pkg.sv =====
// Package for the rotary dial detent-hold key block.
// Holds the shared constants, the per-dial control and event structs and the report struct.
// No dependencies.
package rddh_pkg;

	localparam int MAX_DIALS       = 4;
	localparam int NUM_DIALS_DEF   = 4;
	localparam int TICK_WIDTH_DEF  = 32;

	localparam int POS_W           = 7;
	localparam int BYTE_W          = 8;
	localparam int SIZE_W          = 10;
	localparam int NOW_W           = 32;
	localparam int HOLD_W          = 16;
	localparam int KEY_W           = 12;
	localparam int WIDE_W          = 64;

	localparam int PUSH_SHIFT      = 0;
	localparam int CW_SHIFT        = 4;
	localparam int CCW_SHIFT       = 8;

	localparam logic [POS_W-1:0]  HALF_TURN  = 7'd64;
	localparam logic [SIZE_W-1:0] MIN_SIZE   = 10'd64;
	localparam logic [BYTE_W-1:0] WANTED_ID  = 8'h01;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd50;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             push;
		logic             cw_active;
		logic             ccw_active;
	} dial_ctl_t;

	typedef struct packed {
		logic push;
		logic cw;
		logic ccw;
	} dial_evt_t;

	typedef struct packed {
		logic [BYTE_W-1:0] report_id;
		logic [SIZE_W-1:0] report_size;
		logic [BYTE_W-1:0] dial_byte_0;
		logic [BYTE_W-1:0] dial_byte_1;
		logic [BYTE_W-1:0] dial_byte_2;
		logic [BYTE_W-1:0] dial_byte_3;
		logic [NOW_W-1:0]  now_tick;
	} report_t;

endpackage

// ===== hdl/rotary_dial_detent_hold_keys_top.sv =====
// A word accepted into the input stage register is loaded into the result register
// once that register is empty or its result is not stalled.
// Throughput: one word per cycle while result_stall is low; the per-dial update sits
// between the input stage register and the result register, with dial state fed back.
// Reset (arst_n low, asynchronous): hold_q returns to 50, all keys are released,
// and the next accepted report only records dial states. Depends on rddh_pkg, rddh_dial.
module rotary_dial_detent_hold_keys_top #(
	parameter int NUM_DIALS  = rddh_pkg::NUM_DIALS_DEF,
	parameter int TICK_WIDTH = rddh_pkg::TICK_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rddh_pkg::HOLD_W-1:0]        cfg_data,
	input  logic                               report_valid,
	output logic                               report_stall,
	input  logic [rddh_pkg::BYTE_W-1:0]        report_id,
	input  logic [rddh_pkg::SIZE_W-1:0]        report_size,
	input  logic [rddh_pkg::BYTE_W-1:0]        dial_byte_0,
	input  logic [rddh_pkg::BYTE_W-1:0]        dial_byte_1,
	input  logic [rddh_pkg::BYTE_W-1:0]        dial_byte_2,
	input  logic [rddh_pkg::BYTE_W-1:0]        dial_byte_3,
	input  logic [rddh_pkg::NOW_W-1:0]         now_tick,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               accepted,
	output logic [rddh_pkg::KEY_W-1:0]         key_levels,
	output logic [rddh_pkg::KEY_W-1:0]         key_changed,
	output logic                               sync
);
	import rddh_pkg::*;

	logic [HOLD_W-1:0]     hold_q;
	logic                  primed_q;
	dial_ctl_t             ctl_q      [NUM_DIALS];
	logic [TICK_WIDTH-1:0] cw_dl_q    [NUM_DIALS];
	logic [TICK_WIDTH-1:0] ccw_dl_q   [NUM_DIALS];

	dial_ctl_t             ctl_nxt    [NUM_DIALS];
	logic [TICK_WIDTH-1:0] cw_dl_nxt  [NUM_DIALS];
	logic [TICK_WIDTH-1:0] ccw_dl_nxt [NUM_DIALS];
	dial_evt_t             evt        [NUM_DIALS];
	logic [NUM_DIALS-1:0]  any;

	report_t               rpt_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  accepted_s2;
	logic [KEY_W-1:0]      levels_s2;
	logic [KEY_W-1:0]      changed_s2;
	logic                  sync_s2;

	logic                  advance;
	logic                  step;
	logic                  pass;
	logic [BYTE_W-1:0]     dial_raw   [MAX_DIALS];
	logic [WIDE_W-1:0]     now_wide;
	logic [WIDE_W-1:0]     hold_wide;
	logic [TICK_WIDTH-1:0] now_t;
	logic [TICK_WIDTH-1:0] hold_t;
	logic [TICK_WIDTH-1:0] neg_hold;
	logic                  fresh_reached;
	logic [KEY_W-1:0]      levels_nxt;
	logic [KEY_W-1:0]      changed_nxt;

	// Configuration: writes only while idle; the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_q <= cfg_data;
		end
	end

	// Handshake: the result register frees up when empty or when taken.
	assign advance      = !valid_s2 || !result_stall;
	assign step         = valid_s1 && advance;
	assign report_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!report_stall) begin
			valid_s1 <= report_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (report_valid && !report_stall) begin
			rpt_s1.report_id   <= report_id;
			rpt_s1.report_size <= report_size;
			rpt_s1.dial_byte_0 <= dial_byte_0;
			rpt_s1.dial_byte_1 <= dial_byte_1;
			rpt_s1.dial_byte_2 <= dial_byte_2;
			rpt_s1.dial_byte_3 <= dial_byte_3;
			rpt_s1.now_tick    <= now_tick;
		end
	end

	always_comb begin
		pass        = (rpt_s1.report_size >= MIN_SIZE) && (rpt_s1.report_id == WANTED_ID);
		dial_raw[0] = rpt_s1.dial_byte_0;
		dial_raw[1] = rpt_s1.dial_byte_1;
		dial_raw[2] = rpt_s1.dial_byte_2;
		dial_raw[3] = rpt_s1.dial_byte_3;
		now_wide    = {{(WIDE_W-NOW_W){1'b0}}, rpt_s1.now_tick};
		hold_wide   = {{(WIDE_W-HOLD_W){1'b0}}, hold_q};
		now_t       = now_wide[TICK_WIDTH-1:0];
		hold_t      = hold_wide[TICK_WIDTH-1:0];
		neg_hold    = -hold_t;
		// Deadline now + hold counts as reached when now - deadline is not negative.
		fresh_reached = !neg_hold[TICK_WIDTH-1];
	end

	for (genvar i = 0; i < NUM_DIALS; i++) begin : g_dial
		rddh_dial #(
			.TICK_WIDTH(TICK_WIDTH)
		) u_dial (
			.cur           (ctl_q[i]),
			.raw           (dial_raw[i]),
			.primed        (primed_q),
			.now           (now_t),
			.hold          (hold_t),
			.fresh_reached (fresh_reached),
			.cw_dl         (cw_dl_q[i]),
			.ccw_dl        (ccw_dl_q[i]),
			.nxt           (ctl_nxt[i]),
			.cw_dl_nxt     (cw_dl_nxt[i]),
			.ccw_dl_nxt    (ccw_dl_nxt[i]),
			.evt           (evt[i]),
			.any           (any[i])
		);
	end

	// Dial state moves only on a report that passes the checks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			for (int i = 0; i < NUM_DIALS; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (step && pass) begin
			primed_q <= 1'b1;
			for (int i = 0; i < NUM_DIALS; i++) begin
				ctl_q[i] <= ctl_nxt[i];
			end
		end
	end

	// Deadlines are only read while their key is active.
	always_ff @(posedge clk) begin
		if (step && pass) begin
			for (int i = 0; i < NUM_DIALS; i++) begin
				cw_dl_q[i]  <= cw_dl_nxt[i];
				ccw_dl_q[i] <= ccw_dl_nxt[i];
			end
		end
	end

	always_comb begin
		levels_nxt  = '0;
		changed_nxt = '0;
		for (int i = 0; i < NUM_DIALS; i++) begin
			if (pass) begin
				levels_nxt[i + PUSH_SHIFT] = ctl_nxt[i].push;
				levels_nxt[i + CW_SHIFT]   = ctl_nxt[i].cw_active;
				levels_nxt[i + CCW_SHIFT]  = ctl_nxt[i].ccw_active;
				changed_nxt[i + PUSH_SHIFT] = evt[i].push;
				changed_nxt[i + CW_SHIFT]   = evt[i].cw;
				changed_nxt[i + CCW_SHIFT]  = evt[i].ccw;
			end else begin
				levels_nxt[i + PUSH_SHIFT] = ctl_q[i].push;
				levels_nxt[i + CW_SHIFT]   = ctl_q[i].cw_active;
				levels_nxt[i + CCW_SHIFT]  = ctl_q[i].ccw_active;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			accepted_s2 <= pass;
			levels_s2   <= levels_nxt;
			changed_s2  <= changed_nxt;
			sync_s2     <= pass && primed_q && (|any);
		end
	end

	assign result_valid = valid_s2;
	assign accepted     = accepted_s2;
	assign key_levels   = levels_s2;
	assign key_changed  = changed_s2;
	assign sync         = sync_s2;

	// A rejected report never reports a key event or sync.
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !accepted_s2) |-> (changed_s2 == '0 && !sync_s2))
		else $error("rejected report carries key events");

	// Sync can only follow an accepted report.
	a_sync_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && sync_s2) |-> accepted_s2)
		else $error("sync without an accepted report");

	// Any accepted report leaves the block primed.
	a_primed_after: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pass) |=> primed_q)
		else $error("block not primed after an accepted report");

	// The first accepted report issues no key event.
	a_first_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pass && !primed_q) |=> (changed_s2 == '0 && !sync_s2))
		else $error("key event on the first accepted report");

endmodule

// ===== hdl/rddh_dial.sv =====
// Next-state and key event logic for one dial, purely combinational.
// Depends on rddh_pkg for the control and event structs.
// Deadlines are TICK_WIDTH bits and travel beside the control struct.
module rddh_dial #(
	parameter int TICK_WIDTH = rddh_pkg::TICK_WIDTH_DEF
) (
	input  rddh_pkg::dial_ctl_t                cur,
	input  logic [rddh_pkg::BYTE_W-1:0]        raw,
	input  logic                               primed,
	input  logic [TICK_WIDTH-1:0]              now,
	input  logic [TICK_WIDTH-1:0]              hold,
	input  logic                               fresh_reached,
	input  logic [TICK_WIDTH-1:0]              cw_dl,
	input  logic [TICK_WIDTH-1:0]              ccw_dl,
	output rddh_pkg::dial_ctl_t                nxt,
	output logic [TICK_WIDTH-1:0]              cw_dl_nxt,
	output logic [TICK_WIDTH-1:0]              ccw_dl_nxt,
	output rddh_pkg::dial_evt_t                evt,
	output logic                               any
);
	import rddh_pkg::*;

	logic [POS_W-1:0]      pos;
	logic                  push;
	logic [POS_W-1:0]      delta;
	logic                  turn_cw;
	logic                  turn_ccw;
	logic [TICK_WIDTH-1:0] new_dl;
	logic [TICK_WIDTH-1:0] cw_diff;
	logic [TICK_WIDTH-1:0] ccw_diff;
	logic                  cw_rel;
	logic                  ccw_rel;

	always_comb begin
		pos      = raw[POS_W-1:0];
		push     = raw[POS_W];
		// Offset by a half turn so that the signed mod-128 change is an unsigned compare.
		delta    = pos - cur.position + HALF_TURN;
		turn_cw  = delta > HALF_TURN;
		turn_ccw = delta < HALF_TURN;
		new_dl   = now + hold;
		cw_diff  = now - cw_dl;
		ccw_diff = now - ccw_dl;
		// A freshly set deadline is now + hold, so its release test depends on hold alone.
		cw_rel   = turn_cw ? fresh_reached : (cur.cw_active && !cw_diff[TICK_WIDTH-1]);
		ccw_rel  = turn_ccw ? fresh_reached : (cur.ccw_active && !ccw_diff[TICK_WIDTH-1]);

		nxt.position = pos;
		nxt.push     = push;
		if (primed) begin
			nxt.cw_active  = (cur.cw_active | turn_cw) & ~cw_rel;
			nxt.ccw_active = (cur.ccw_active | turn_ccw) & ~ccw_rel;
			cw_dl_nxt      = turn_cw ? new_dl : cw_dl;
			ccw_dl_nxt     = turn_ccw ? new_dl : ccw_dl;
			evt.cw         = (turn_cw & ~cur.cw_active) | cw_rel;
			evt.ccw        = (turn_ccw & ~cur.ccw_active) | ccw_rel;
			evt.push       = push != cur.push;
			any            = turn_cw | turn_ccw | cw_rel | ccw_rel | evt.push;
		end else begin
			nxt.cw_active  = cur.cw_active;
			nxt.ccw_active = cur.ccw_active;
			cw_dl_nxt      = cw_dl;
			ccw_dl_nxt     = ccw_dl;
			evt            = '0;
			any            = 1'b0;
		end
	end

endmodule
